FILE: rtl/core/ilt_pkg.sv
// ---------------------------------------------------------------------------
// ilt_pkg
// Types, codes and character classes shared by the INI line tokenizer.
// ---------------------------------------------------------------------------
package ilt_pkg;

	typedef struct packed {
		logic       opcode;
		logic [7:0] char_byte;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] out_byte;
		logic [1:0] line_status;
		logic [3:0] error_code;
		logic       last_of_item;
	} rsp_t;

	// Compact token: data is the character, zero for a value start, or {2'b00, status, error} on line end
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
	} token_t;

	typedef struct packed {
		logic   valid;
		token_t token;
	} token_push_t;

	localparam logic       OP_BYTE = 1'b0;
	localparam logic       OP_EOT  = 1'b1;

	localparam logic [2:0] KIND_SECT_CHAR = 3'd0;
	localparam logic [2:0] KIND_KEY_CHAR  = 3'd1;
	localparam logic [2:0] KIND_VAL_START = 3'd2;
	localparam logic [2:0] KIND_VAL_CHAR  = 3'd3;
	localparam logic [2:0] KIND_LINE_END  = 3'd4;

	localparam logic [1:0] ST_ENTRY   = 2'd0;
	localparam logic [1:0] ST_BLANK   = 2'd1;
	localparam logic [1:0] ST_SECTION = 2'd2;
	localparam logic [1:0] ST_ERROR   = 2'd3;

	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_SECT_OPEN    = 4'd1;
	localparam logic [3:0] ERR_SECT_BYTE    = 4'd2;
	localparam logic [3:0] ERR_EQ_MISSING   = 4'd3;
	localparam logic [3:0] ERR_KEY_BYTE     = 4'd4;
	localparam logic [3:0] ERR_VAL_MISSING  = 4'd5;
	localparam logic [3:0] ERR_QUOTE_OPEN   = 4'd6;
	localparam logic [3:0] ERR_EMPTY_IDENT  = 4'd7;
	localparam logic [3:0] ERR_VAL_BYTE     = 4'd8;
	localparam logic [3:0] ERR_NO_SECTION   = 4'd9;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	function automatic logic is_ident(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic logic is_comment(input logic [7:0] c);
		return c == CH_SEMI || c == CH_HASH;
	endfunction

	function automatic logic is_quote(input logic [7:0] c);
		return c == CH_SQUOTE || c == CH_DQUOTE;
	endfunction

endpackage

FILE: rtl/core/ilt_front.sv
// ---------------------------------------------------------------------------
// ilt_front
// Line parser: accepts requests, classifies bytes and pushes tokens.
// ---------------------------------------------------------------------------
module ilt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  ilt_pkg::req_t        req_data,
	input  logic                 q_space,
	output ilt_pkg::token_push_t push
);
	import ilt_pkg::*;

	typedef enum logic [3:0] {
		PH_START     = 4'd0,
		PH_COMMENT   = 4'd1,
		PH_SECT      = 4'd2,
		PH_SECT_DONE = 4'd3,
		PH_KEY_Q     = 4'd4,
		PH_KEY_U     = 4'd5,
		PH_KEY_AFTER = 4'd6,
		PH_VAL_WS    = 4'd7,
		PH_VAL_Q     = 4'd8,
		PH_VAL_U     = 4'd9,
		PH_VAL_AFTER = 4'd10,
		PH_VAL_END   = 4'd11,
		PH_ERROR     = 4'd12
	} phase_t;

	phase_t     phase_q, phase_d;
	logic       quote_q, quote_d;
	logic       sect_q, sect_d;
	logic       pend_q, pend_d;
	logic [3:0] err_q, err_d;
	logic       bytes_q, bytes_d;
	logic       accept;
	logic [7:0] c;
	logic [7:0] delim;
	logic [1:0] fin_status;
	logic [3:0] fin_err;

	assign req_ready = q_space;
	assign accept    = req_valid && q_space;
	assign c         = req_data.char_byte;
	assign delim     = quote_q ? CH_DQUOTE : CH_SQUOTE;

	always_comb begin
		fin_status = ST_BLANK;
		fin_err    = ERR_NONE;
		unique case (phase_q)
			PH_SECT: begin
				fin_status = ST_ERROR;
				fin_err    = ERR_SECT_OPEN;
			end
			PH_SECT_DONE: fin_status = ST_SECTION;
			PH_KEY_Q, PH_VAL_Q: begin
				fin_status = ST_ERROR;
				fin_err    = ERR_QUOTE_OPEN;
			end
			PH_KEY_U, PH_KEY_AFTER: begin
				fin_status = ST_ERROR;
				fin_err    = ERR_EQ_MISSING;
			end
			PH_VAL_WS: begin
				fin_status = ST_ERROR;
				fin_err    = ERR_VAL_MISSING;
			end
			PH_VAL_U, PH_VAL_AFTER, PH_VAL_END: begin
				if (sect_q) begin
					fin_status = ST_ENTRY;
				end else begin
					fin_status = ST_ERROR;
					fin_err    = ERR_NO_SECTION;
				end
			end
			PH_ERROR: begin
				fin_status = ST_ERROR;
				fin_err    = err_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		quote_d    = quote_q;
		sect_d     = sect_q;
		pend_d     = pend_q;
		err_d      = err_q;
		bytes_d    = bytes_q;
		push.valid = 1'b0;
		push.token = '{kind: KIND_LINE_END, data: {2'b00, fin_status, fin_err}};
		if (accept) begin
			if (req_data.opcode == OP_EOT) begin
				push.valid = bytes_q;
				phase_d    = PH_START;
				quote_d    = 1'b0;
				sect_d     = 1'b0;
				pend_d     = 1'b0;
				err_d      = ERR_NONE;
				bytes_d    = 1'b0;
			end else if (c == CH_LF) begin
				push.valid = 1'b1;
				phase_d    = PH_START;
				quote_d    = 1'b0;
				pend_d     = 1'b0;
				err_d      = ERR_NONE;
				bytes_d    = 1'b0;
			end else begin
				bytes_d = 1'b1;
				unique case (phase_q)
					PH_START: begin
						if (is_ws(c)) begin
						end else if (is_comment(c)) begin
							phase_d = PH_COMMENT;
						end else if (c == CH_LBRACK) begin
							pend_d  = 1'b0;
							phase_d = PH_SECT;
						end else if (is_quote(c)) begin
							quote_d = (c == CH_DQUOTE);
							phase_d = PH_KEY_Q;
						end else if (is_ident(c)) begin
							phase_d    = PH_KEY_U;
							push.valid = 1'b1;
							push.token = '{kind: KIND_KEY_CHAR, data: c};
						end else begin
							err_d   = ERR_EMPTY_IDENT;
							phase_d = PH_ERROR;
						end
					end
					PH_SECT: begin
						if (is_ident(c)) begin
							pend_d     = 1'b1;
							push.valid = 1'b1;
							push.token = '{kind: KIND_SECT_CHAR, data: c};
						end else if (c == CH_RBRACK) begin
							sect_d  = pend_q;
							phase_d = PH_SECT_DONE;
						end else begin
							err_d   = ERR_SECT_BYTE;
							phase_d = PH_ERROR;
						end
					end
					PH_KEY_Q: begin
						if (c == delim) begin
							phase_d = PH_KEY_AFTER;
						end else begin
							push.valid = 1'b1;
							push.token = '{kind: KIND_KEY_CHAR, data: c};
						end
					end
					PH_KEY_U, PH_KEY_AFTER: begin
						if (phase_q == PH_KEY_U && is_ident(c)) begin
							push.valid = 1'b1;
							push.token = '{kind: KIND_KEY_CHAR, data: c};
						end else if (is_ws(c)) begin
							phase_d = PH_KEY_AFTER;
						end else if (c == CH_EQUALS) begin
							phase_d    = PH_VAL_WS;
							push.valid = 1'b1;
							push.token = '{kind: KIND_VAL_START, data: 8'h00};
						end else begin
							err_d   = ERR_KEY_BYTE;
							phase_d = PH_ERROR;
						end
					end
					PH_VAL_WS: begin
						if (is_ws(c)) begin
						end else if (is_quote(c)) begin
							quote_d = (c == CH_DQUOTE);
							phase_d = PH_VAL_Q;
						end else if (is_ident(c)) begin
							phase_d    = PH_VAL_U;
							push.valid = 1'b1;
							push.token = '{kind: KIND_VAL_CHAR, data: c};
						end else begin
							err_d   = ERR_EMPTY_IDENT;
							phase_d = PH_ERROR;
						end
					end
					PH_VAL_Q: begin
						if (c == delim) begin
							phase_d = PH_VAL_AFTER;
						end else begin
							push.valid = 1'b1;
							push.token = '{kind: KIND_VAL_CHAR, data: c};
						end
					end
					PH_VAL_U, PH_VAL_AFTER: begin
						if (phase_q == PH_VAL_U && is_ident(c)) begin
							push.valid = 1'b1;
							push.token = '{kind: KIND_VAL_CHAR, data: c};
						end else if (is_ws(c)) begin
							phase_d = PH_VAL_AFTER;
						end else if (is_comment(c)) begin
							phase_d = PH_VAL_END;
						end else if (c == CH_COMMA) begin
							phase_d    = PH_VAL_WS;
							push.valid = 1'b1;
							push.token = '{kind: KIND_VAL_START, data: 8'h00};
						end else begin
							err_d   = ERR_VAL_BYTE;
							phase_d = PH_ERROR;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			quote_q <= 1'b0;
			sect_q  <= 1'b0;
			pend_q  <= 1'b0;
			err_q   <= ERR_NONE;
			bytes_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			quote_q <= quote_d;
			sect_q  <= sect_d;
			pend_q  <= pend_d;
			err_q   <= err_d;
			bytes_q <= bytes_d;
		end
	end

endmodule

FILE: rtl/core/ilt_queue.sv
// ---------------------------------------------------------------------------
// ilt_queue
// Two-entry token queue between the parser and the output stage.
// ---------------------------------------------------------------------------
module ilt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ilt_pkg::token_push_t push,
	output logic                 space,
	output logic                 pop_valid,
	output ilt_pkg::token_t      pop_token,
	input  logic                 pop
);
	import ilt_pkg::*;

	token_t     entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign space     = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_token = entry_q[rd_ptr_q];
	assign do_push   = push.valid && space;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

FILE: rtl/core/ilt_back.sv
// ---------------------------------------------------------------------------
// ilt_back
// Output stage: expands tokens into result records and holds them.
// ---------------------------------------------------------------------------
module ilt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	input  ilt_pkg::token_t tok,
	output logic            tok_pop,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ilt_pkg::rsp_t   rsp_data
);
	import ilt_pkg::*;

	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_d;

	assign tok_pop   = tok_valid && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		rsp_d              = '0;
		rsp_d.kind         = tok.kind;
		rsp_d.last_of_item = 1'b1;
		case (tok.kind)
			KIND_SECT_CHAR, KIND_KEY_CHAR, KIND_VAL_CHAR: rsp_d.out_byte = tok.data;
			KIND_LINE_END: begin
				rsp_d.line_status = tok.data[5:4];
				rsp_d.error_code  = tok.data[3:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (tok_pop) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/ini_line_tokenizer.sv
// ---------------------------------------------------------------------------
// ini_line_tokenizer
// Streaming INI line tokenizer, one text byte per request.
// ---------------------------------------------------------------------------
// Requests carry an opcode (text byte or end of text) and a byte; byte 10
// closes a line. Each request yields at most one result: a section, key or
// value character, a value-start marker, or a line-end record with status
// and first error code. last_of_item is always set.
// Throughput: one request per cycle while the token queue has space. A
// taken request's token is written into the queue, then moved into the
// output register once that register is free or being read.
// A two-entry token queue sits between parser and output register, so
// requests keep flowing while a result waits; req_ready drops only when the
// queue is full, i.e. with one result held in the output register and two
// more tokens queued behind it.
// Reset clears the parser to line start with no section active and empties
// the queue and output register; no clearing pass is needed.
// ---------------------------------------------------------------------------
module ini_line_tokenizer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ilt_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ilt_pkg::rsp_t rsp_data
);
	import ilt_pkg::*;

	token_push_t push;
	logic        q_space;
	logic        q_valid;
	token_t      q_token;
	logic        q_pop;

	ilt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.q_space   (q_space),
		.push      (push)
	);

	ilt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (q_space),
		.pop_valid (q_valid),
		.pop_token (q_token),
		.pop       (q_pop)
	);

	ilt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok       (q_token),
		.tok_pop   (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

FILE: rtl/core/ilt_checker.sv
// ---------------------------------------------------------------------------
// ilt_checker
// Port-level checks on the tokenizer result channel.
// ---------------------------------------------------------------------------
module ilt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ilt_pkg::rsp_t rsp_data
);
	import ilt_pkg::*;

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.last_of_item)
		else $error("last_of_item clear");

	a_token_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.kind != KIND_LINE_END |->
			rsp_data.line_status == ST_ENTRY && rsp_data.error_code == ERR_NONE &&
			(rsp_data.kind == KIND_SECT_CHAR || rsp_data.kind == KIND_KEY_CHAR ||
			 rsp_data.kind == KIND_VAL_START || rsp_data.kind == KIND_VAL_CHAR))
		else $error("bad token result");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.kind == KIND_LINE_END |->
			rsp_data.out_byte == 8'h00 &&
			((rsp_data.error_code != ERR_NONE) == (rsp_data.line_status == ST_ERROR)))
		else $error("bad line-end result");

endmodule

bind ini_line_tokenizer ilt_checker u_ilt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);
